/* hdl/atp_pkg.sv */
// ----------------------------------------------------------------------------
// atp_pkg
// Shared constants, types and the sine table generator for the angle pll.
// ----------------------------------------------------------------------------
package atp_pkg;

  localparam int ATP_SINE_DEPTH = 256;
  localparam int ATP_SAMPLE_RATE_HZ = 2000;
  localparam int ATP_SPEED_MUL = ATP_SAMPLE_RATE_HZ * 60;

  localparam int ATP_QUARTER = 16384;
  localparam int ATP_DIV_STEPS = 30;

  localparam longint ATP_POLY_A = 51472;
  localparam longint ATP_POLY_B = 21167;
  localparam longint ATP_POLY_C = 2611;

  typedef enum logic [1:0] {
    CFG_LOOP_ENABLE = 2'd0,
    CFG_PROP_GAIN   = 2'd1,
    CFG_INT_GAIN    = 2'd2,
    CFG_MAX_STEP    = 2'd3
  } cfg_idx_e;

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_DIV    = 14'b00000000000010,
    ST_LOOK_S = 14'b00000000000100,
    ST_LOOK_C = 14'b00000000001000,
    ST_MUL_A  = 14'b00000000010000,
    ST_MUL_B  = 14'b00000000100000,
    ST_ERR    = 14'b00000001000000,
    ST_INTEG  = 14'b00000010000000,
    ST_MUL_P  = 14'b00000100000000,
    ST_MUL_I  = 14'b00001000000000,
    ST_STEP   = 14'b00010000000000,
    ST_MUL_S  = 14'b00100000000000,
    ST_SPEED  = 14'b01000000000000,
    ST_DONE   = 14'b10000000000000
  } state_e;

  // quarter-wave sine polynomial, x in q15 over 0..1 of a quarter turn
  function automatic logic [14:0] sine_poly(input longint x);
    longint x2;
    longint t;
    x2 = (x * x) >>> 15;
    t = ATP_POLY_B - ((ATP_POLY_C * x2) >>> 15);
    t = ATP_POLY_A - ((t * x2) >>> 15);
    t = (t * x) >>> 15;
    if (t > 32767) begin
      t = 32767;
    end
    return t[14:0];
  endfunction

endpackage

/* hdl/angle_tracking_pll_top.sv */
// ----------------------------------------------------------------------------
// angle_tracking_pll_top
// Angle-tracking pll: cross-product phase error, pi loop, angle integrator.
// ----------------------------------------------------------------------------
// One input beat is taken at a time: ready drops once a beat is accepted and
// rises again only after its result is loaded. With the loop enabled a
// restoring divider forms the integral limit, then twelve sequencer steps,
// the multiplying ones sharing one 17 x 32 bit multiplier, load the result;
// with the loop disabled the sequencer goes straight to its last step and the
// held state is returned. A finished result sits in the output
// register until taken; the block waits in its last step only if the previous
// result has still not been taken.
// ----------------------------------------------------------------------------
module angle_tracking_pll_top #(
  parameter int SINE_TABLE_DEPTH = atp_pkg::ATP_SINE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic        [1:0]  cfg_idx_i,
  input  logic        [15:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] meas_sine_i,
  input  logic signed [15:0] meas_cosine_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic        [15:0] angle_estimate_o,
  output logic signed [15:0] freq_step_o,
  output logic signed [16:0] speed_rpm_o,
  output logic signed [15:0] phase_error_o
);

  localparam int PROD_W = 49;
  localparam int SUM_W  = 50;
  localparam int CNT_W  = $clog2(atp_pkg::ATP_DIV_STEPS);

  atp_pkg::state_e state_q, state_d;

  logic               loop_enable_q;
  logic        [15:0] prop_gain_q;
  logic        [15:0] int_gain_q;
  logic        [14:0] max_step_q;

  logic        [15:0] angle_q;
  logic signed [31:0] integral_q;
  logic signed [15:0] last_step_q;
  logic signed [15:0] last_error_q;
  logic signed [16:0] last_speed_q;

  logic signed [15:0] sm_q, cm_q, se_q, ce_q;
  logic signed [15:0] err_q;
  logic signed [31:0] integ_q;
  logic signed [PROD_W-1:0] prod_q, acc_q;
  logic        [29:0] div_n_q;
  logic        [15:0] rem_q;
  logic   [CNT_W-1:0] cnt_q;

  logic               out_valid_q;
  logic        [15:0] out_angle_q;
  logic signed [15:0] out_step_q;
  logic signed [16:0] out_speed_q;
  logic signed [15:0] out_error_q;

  logic               in_acc;
  logic               out_load;
  logic        [15:0] look_angle;
  logic signed [15:0] look_sine;
  logic signed [16:0] mul_a;
  logic signed [31:0] mul_b;
  logic        [16:0] trial;
  logic               qbit;
  logic signed [SUM_W-1:0] diff, step_sum;
  logic signed [SUM_W-1:0] err_sh, step_sh;
  logic signed [15:0] err_d;
  logic signed [32:0] integ_sum, lim;
  logic signed [31:0] integ_d;
  logic signed [SUM_W-1:0] ms_pos;
  logic signed [15:0] step_d;
  logic signed [PROD_W-1:0] spd_adj, spd_sh;
  logic signed [16:0] speed_d;

  assign in_ready_o = (state_q == atp_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == atp_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  assign look_angle = (state_q == atp_pkg::ST_LOOK_C)
                    ? angle_q + 16'(atp_pkg::ATP_QUARTER) : angle_q;

  atp_sine #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_sine (
    .angle_i(look_angle),
    .sine_o (look_sine)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = 17'sd0;
    mul_b = 32'sd0;
    case (state_q)
      atp_pkg::ST_MUL_A: begin
        mul_a = 17'(sm_q);
        mul_b = 32'(ce_q);
      end
      atp_pkg::ST_MUL_B: begin
        mul_a = 17'(cm_q);
        mul_b = 32'(se_q);
      end
      atp_pkg::ST_MUL_P: begin
        mul_a = $signed({1'b0, prop_gain_q});
        mul_b = 32'(err_q);
      end
      atp_pkg::ST_MUL_I: begin
        mul_a = $signed({1'b0, int_gain_q});
        mul_b = integ_q;
      end
      atp_pkg::ST_MUL_S: begin
        mul_a = 17'(last_step_q);
        mul_b = 32'(atp_pkg::ATP_SPEED_MUL);
      end
      default: begin
        mul_a = 17'sd0;
        mul_b = 32'sd0;
      end
    endcase
  end

  // datapath combinational terms
  always_comb begin
    trial = {rem_q, div_n_q[29]};
    qbit  = (trial >= {1'b0, int_gain_q});

    diff   = SUM_W'(acc_q) - SUM_W'(prod_q);
    err_sh = diff >>> 15;
    if (err_sh > 50'sd32767) begin
      err_d = 16'sh7fff;
    end else if (err_sh < -50'sd32768) begin
      err_d = 16'sh8000;
    end else begin
      err_d = err_sh[15:0];
    end

    lim = (int_gain_q == 16'd0) ? 33'sh040000000 : $signed({3'b000, div_n_q});
    integ_sum = 33'(integral_q) + 33'(err_q);
    if (integ_sum > lim) begin
      integ_d = lim[31:0];
    end else if (integ_sum < -lim) begin
      integ_d = 32'(-lim);
    end else begin
      integ_d = integ_sum[31:0];
    end

    step_sum = SUM_W'(acc_q) + SUM_W'(prod_q);
    step_sh  = step_sum >>> 15;
    ms_pos   = $signed({35'd0, max_step_q});
    if (step_sh > ms_pos) begin
      step_d = $signed({1'b0, max_step_q});
    end else if (step_sh < -ms_pos) begin
      step_d = -$signed({1'b0, max_step_q});
    end else begin
      step_d = step_sh[15:0];
    end

    spd_adj = prod_q[PROD_W-1] ? prod_q + PROD_W'(65535) : prod_q;
    spd_sh  = spd_adj >>> 16;
    if (spd_sh > 49'sd65535) begin
      speed_d = 17'sh0ffff;
    end else if (spd_sh < -49'sd65536) begin
      speed_d = 17'sh10000;
    end else begin
      speed_d = spd_sh[16:0];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      atp_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = loop_enable_q ? atp_pkg::ST_DIV : atp_pkg::ST_DONE;
        end
      end
      atp_pkg::ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = atp_pkg::ST_LOOK_S;
        end
      end
      atp_pkg::ST_LOOK_S: state_d = atp_pkg::ST_LOOK_C;
      atp_pkg::ST_LOOK_C: state_d = atp_pkg::ST_MUL_A;
      atp_pkg::ST_MUL_A:  state_d = atp_pkg::ST_MUL_B;
      atp_pkg::ST_MUL_B:  state_d = atp_pkg::ST_ERR;
      atp_pkg::ST_ERR:    state_d = atp_pkg::ST_INTEG;
      atp_pkg::ST_INTEG:  state_d = atp_pkg::ST_MUL_P;
      atp_pkg::ST_MUL_P:  state_d = atp_pkg::ST_MUL_I;
      atp_pkg::ST_MUL_I:  state_d = atp_pkg::ST_STEP;
      atp_pkg::ST_STEP:   state_d = atp_pkg::ST_MUL_S;
      atp_pkg::ST_MUL_S:  state_d = atp_pkg::ST_SPEED;
      atp_pkg::ST_SPEED:  state_d = atp_pkg::ST_DONE;
      atp_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = atp_pkg::ST_IDLE;
        end
      end
      default: state_d = atp_pkg::ST_IDLE;
    endcase
  end

  // control and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= atp_pkg::ST_IDLE;
      loop_enable_q <= 1'b0;
      prop_gain_q   <= 16'd2048;
      int_gain_q    <= 16'd64;
      max_step_q    <= 15'd4096;
      angle_q       <= 16'd0;
      integral_q    <= 32'sd0;
      last_step_q   <= 16'sd0;
      last_error_q  <= 16'sd0;
      last_speed_q  <= 17'sd0;
      out_valid_q   <= 1'b0;
      cnt_q         <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (atp_pkg::cfg_idx_e'(cfg_idx_i))
          atp_pkg::CFG_LOOP_ENABLE: loop_enable_q <= cfg_data_i[0];
          atp_pkg::CFG_PROP_GAIN:   prop_gain_q   <= cfg_data_i;
          atp_pkg::CFG_INT_GAIN:    int_gain_q    <= cfg_data_i;
          atp_pkg::CFG_MAX_STEP:    max_step_q    <= cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        cnt_q <= CNT_W'(atp_pkg::ATP_DIV_STEPS - 1);
      end else if (state_q == atp_pkg::ST_DIV) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (state_q == atp_pkg::ST_STEP) begin
        angle_q      <= angle_q + $unsigned(step_d);
        integral_q   <= integ_q;
        last_step_q  <= step_d;
        last_error_q <= err_q;
      end
      if (state_q == atp_pkg::ST_SPEED) begin
        last_speed_q <= speed_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (in_acc) begin
      sm_q    <= meas_sine_i;
      cm_q    <= meas_cosine_i;
      div_n_q <= {max_step_q, 15'd0};
      rem_q   <= 16'd0;
    end else if (state_q == atp_pkg::ST_DIV) begin
      rem_q   <= qbit ? 16'(trial - {1'b0, int_gain_q}) : trial[15:0];
      div_n_q <= {div_n_q[28:0], qbit};
    end
    if (state_q == atp_pkg::ST_LOOK_S) begin
      se_q <= look_sine;
    end
    if (state_q == atp_pkg::ST_LOOK_C) begin
      ce_q <= look_sine;
    end
    if (state_q == atp_pkg::ST_MUL_B || state_q == atp_pkg::ST_MUL_I) begin
      acc_q <= prod_q;
    end
    if (state_q == atp_pkg::ST_ERR) begin
      err_q <= err_d;
    end
    if (state_q == atp_pkg::ST_INTEG) begin
      integ_q <= integ_d;
    end
    if (out_load) begin
      out_angle_q <= angle_q;
      out_step_q  <= last_step_q;
      out_speed_q <= last_speed_q;
      out_error_q <= last_error_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign angle_estimate_o = out_angle_q;
  assign freq_step_o      = out_step_q;
  assign speed_rpm_o      = out_speed_q;
  assign phase_error_o    = out_error_q;

endmodule

/* hdl/atp_sine.sv */
// ----------------------------------------------------------------------------
// atp_sine
// Full-turn sine lookup from a quarter-wave constant table.
// ----------------------------------------------------------------------------
module atp_sine #(
  parameter int SINE_TABLE_DEPTH = atp_pkg::ATP_SINE_DEPTH
) (
  input  logic        [15:0] angle_i,
  output logic signed [15:0] sine_o
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int MUL_W = 15 + $clog2(SINE_TABLE_DEPTH + 1);

  logic [14:0] lut [SINE_TABLE_DEPTH];

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_lut
    assign lut[g] = atp_pkg::sine_poly(longint'((g * 32768) / SINE_TABLE_DEPTH));
  end

  logic [1:0]       quad;
  logic [14:0]      u;
  logic [MUL_W-1:0] pos;
  logic [IDX_W-1:0] idx;
  logic [14:0]      mag;

  always_comb begin
    quad = angle_i[15:14];
    u    = quad[0] ? 15'(atp_pkg::ATP_QUARTER) - {1'b0, angle_i[13:0]}
                   : {1'b0, angle_i[13:0]};
    pos  = MUL_W'(u) * MUL_W'(SINE_TABLE_DEPTH);
    idx  = pos[14 +: IDX_W];
    mag  = u[14] ? 15'h7fff : lut[idx];
    sine_o = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the angle-tracking pll. Directed samples cover the
// field extremes, a held loop, zero integral gain, zero step limit and maximum
// gains. Randomised phases then feed rotating sine/cosine pairs with jitter,
// angle jumps and raw noise under random loop settings. A tracker class
// predicts every result beat, and both handshake sides idle at random.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic        [15:0] angle;
  logic signed [15:0] step;
  logic signed [16:0] rpm;
  logic signed [15:0] err;
} pll_estimate_t;

class pll_tracker;
  int            sine_lut[atp_pkg::ATP_SINE_DEPTH];
  bit            loop_on;
  int            kp;
  int            ki;
  int            step_limit;
  logic [15:0]   angle;
  int            integral;
  int            step_held;
  int            err_held;
  pll_estimate_t expected_estimates[$];
  int            fails;
  int            reported;

  function new();
    longint x;
    longint x2;
    longint t;
    for (int i = 0; i < atp_pkg::ATP_SINE_DEPTH; i++) begin
      x = (longint'(i) << 15) / atp_pkg::ATP_SINE_DEPTH;
      x2 = (x * x) >>> 15;
      t = atp_pkg::ATP_POLY_B - ((atp_pkg::ATP_POLY_C * x2) >>> 15);
      t = atp_pkg::ATP_POLY_A - ((t * x2) >>> 15);
      t = (t * x) >>> 15;
      if (t > 32767) begin
        t = 32767;
      end
      sine_lut[i] = int'(t);
    end
    loop_on = 1'b0;
    kp = 2048;
    ki = 64;
    step_limit = 4096;
    angle = '0;
    integral = 0;
    step_held = 0;
    err_held = 0;
    fails = 0;
    reported = 0;
  endfunction

  function void set_reg(atp_pkg::cfg_idx_e idx, logic [15:0] d);
    case (idx)
      atp_pkg::CFG_LOOP_ENABLE: loop_on = d[0];
      atp_pkg::CFG_PROP_GAIN:   kp = int'(d);
      atp_pkg::CFG_INT_GAIN:    ki = int'(d);
      default:                  step_limit = int'(d[14:0]);
    endcase
  endfunction

  // table sine of a 16-bit turn fraction
  function int wave(logic [15:0] a);
    int u;
    int mag;
    u = int'(a[13:0]);
    if (a[14]) begin
      u = atp_pkg::ATP_QUARTER - u;
    end
    if (u >= atp_pkg::ATP_QUARTER) begin
      mag = 32767;
    end else begin
      mag = sine_lut[(u * atp_pkg::ATP_SINE_DEPTH) >> 14];
    end
    return a[15] ? -mag : mag;
  endfunction

  // one pi loop update per accepted sample while the loop is enabled
  function void track_sample(logic signed [15:0] s, logic signed [15:0] c);
    longint se;
    longint ce;
    longint err;
    longint lim;
    longint integ;
    longint acc;
    longint stp;
    longint rpm;
    pll_estimate_t e;
    if (loop_on) begin
      se = wave(angle);
      ce = wave(angle + 16'd16384);
      err = (longint'(s) * ce - longint'(c) * se) >>> 15;
      if (err > 32767) begin
        err = 32767;
      end
      if (err < -32768) begin
        err = -32768;
      end
      if (ki == 0) begin
        lim = longint'(1) << 30;
      end else begin
        lim = (longint'(step_limit) << 15) / longint'(ki);
      end
      integ = longint'(integral) + err;
      if (integ > lim) begin
        integ = lim;
      end
      if (integ < -lim) begin
        integ = -lim;
      end
      acc = longint'(kp) * err + longint'(ki) * integ;
      stp = acc >>> 15;
      if (stp > step_limit) begin
        stp = step_limit;
      end
      if (stp < -step_limit) begin
        stp = -step_limit;
      end
      integral = int'(integ);
      err_held = int'(err);
      step_held = int'(stp);
      angle = angle + stp[15:0];
    end
    rpm = (longint'(step_held) * atp_pkg::ATP_SPEED_MUL) / 65536;
    if (rpm > 65535) begin
      rpm = 65535;
    end
    if (rpm < -65536) begin
      rpm = -65536;
    end
    e.angle = angle;
    e.step = step_held[15:0];
    e.rpm = rpm[16:0];
    e.err = err_held[15:0];
    expected_estimates.push_back(e);
  endfunction

  function void check_result(pll_estimate_t got);
    pll_estimate_t want;
    if (expected_estimates.size() == 0) begin
      fails++;
      if (reported < 10) begin
        reported++;
        $display("unexpected result beat: angle %0d step %0d rpm %0d err %0d",
                 got.angle, got.step, got.rpm, got.err);
      end
      return;
    end
    want = expected_estimates.pop_front();
    if (got.angle !== want.angle || got.step !== want.step ||
        got.rpm !== want.rpm || got.err !== want.err) begin
      fails++;
      if (reported < 10) begin
        reported++;
        $display("mismatch at %0t: expected angle %0d step %0d rpm %0d err %0d",
                 $realtime, want.angle, want.step, want.rpm, want.err);
        $display("                   got angle %0d step %0d rpm %0d err %0d",
                 got.angle, got.step, got.rpm, got.err);
      end
    end
  endfunction

  function int pending();
    return expected_estimates.size();
  endfunction

  function void close();
    if (expected_estimates.size() != 0) begin
      $display("result beats never seen: %0d", expected_estimates.size());
      fails += expected_estimates.size();
    end
  endfunction
endclass

module tb;

  localparam int TOTAL_ITEMS = 2025;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 60;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic        [1:0]  cfg_idx_i;
  logic        [15:0] cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [15:0] meas_sine_i;
  logic signed [15:0] meas_cosine_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic        [15:0] angle_estimate_o;
  logic signed [15:0] freq_step_o;
  logic signed [16:0] speed_rpm_o;
  logic signed [15:0] phase_error_o;

  pll_tracker sb;
  bit         send_idle;
  bit         recv_idle;
  int         samples_sent;

  angle_tracking_pll_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .meas_sine_i     (meas_sine_i),
    .meas_cosine_i   (meas_cosine_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .angle_estimate_o(angle_estimate_o),
    .freq_step_o     (freq_step_o),
    .speed_rpm_o     (speed_rpm_o),
    .phase_error_o   (phase_error_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic signed [15:0] sat16(input int v);
    if (v > 32767) begin
      return 16'sh7fff;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  task automatic send_sample(input logic signed [15:0] s, input logic signed [15:0] c);
    int gap;
    gap = send_idle ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    meas_sine_i <= s;
    meas_cosine_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
    sb.track_sample(s, c);
    samples_sent++;
  endtask

  // hold off the sender until every outstanding beat has come back
  task automatic settle(input int cycles);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input atp_pkg::cfg_idx_e idx, input logic [15:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    sb.set_reg(idx, d);
  endtask

  task automatic program_loop(input bit en, input logic [15:0] pg, input logic [15:0] ig,
                              input logic [14:0] ms);
    settle(4);
    write_reg(atp_pkg::CFG_LOOP_ENABLE, {15'd0, en});
    write_reg(atp_pkg::CFG_PROP_GAIN, pg);
    write_reg(atp_pkg::CFG_INT_GAIN, ig);
    write_reg(atp_pkg::CFG_MAX_STEP, {1'b0, ms});
    cfg_we_i <= 1'b0;
    send_idle = ($urandom_range(0, 3) != 0);
    recv_idle = ($urandom_range(0, 3) != 0);
  endtask

  task automatic program_random();
    logic [15:0] pg;
    logic [15:0] ig;
    logic [14:0] ms;
    case ($urandom_range(0, 3))
      0:       pg = 16'd0;
      1:       pg = 16'hffff;
      2:       pg = 16'($urandom);
      default: pg = 16'($urandom_range(0, 8192));
    endcase
    case ($urandom_range(0, 3))
      0:       ig = 16'd0;
      1:       ig = 16'hffff;
      2:       ig = 16'($urandom);
      default: ig = 16'($urandom_range(0, 512));
    endcase
    case ($urandom_range(0, 5))
      0:       ms = 15'd0;
      1:       ms = 15'h7fff;
      2, 3:    ms = 15'($urandom_range(0, 32767));
      default: ms = 15'($urandom_range(1, 4096));
    endcase
    program_loop($urandom_range(0, 99) < 85, pg, ig, ms);
  endtask

  initial begin : result_sink
    int stall;
    pll_estimate_t got;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = recv_idle ? $urandom_range(0, 17) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.angle = angle_estimate_o;
      got.step = freq_step_o;
      got.rpm = speed_rpm_o;
      got.err = phase_error_o;
      sb.check_result(got);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int unsigned theta;
    int rate;
    int amp;
    int jit;
    int n;
    logic signed [15:0] s;
    logic signed [15:0] c;
    sb = new();
    samples_sent = 0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = atp_pkg::CFG_LOOP_ENABLE;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    meas_sine_i = '0;
    meas_cosine_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // loop held after reset
    send_sample(16'sh0000, 16'sh0000);
    send_sample(16'sh7fff, 16'sh8000);

    program_loop(1'b1, 16'd2048, 16'd64, 15'd4096);
    send_sample(16'sh7fff, 16'sh0000);
    send_sample(16'sh8000, 16'sh0000);
    send_sample(16'sh0000, 16'sh7fff);
    send_sample(16'sh0000, 16'sh8000);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'shffff, 16'shffff);

    // zero integral gain with the widest limits
    program_loop(1'b1, 16'hffff, 16'd0, 15'h7fff);
    send_sample(16'sh7fff, 16'sh0000);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000);

    // zero step limit
    program_loop(1'b1, 16'hffff, 16'hffff, 15'd0);
    send_sample(16'sh7fff, 16'sh0000);
    send_sample(16'sh8000, 16'sh0000);

    // full integral gain, unit limit
    program_loop(1'b1, 16'd0, 16'hffff, 15'd1);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);

    program_loop(1'b0, 16'd2048, 16'd64, 15'd4096);
    send_sample(16'sh1234, 16'shedcb);
    send_sample(16'sh7fff, 16'sh7fff);

    while (samples_sent < TOTAL_ITEMS) begin
      program_random();
      amp = $urandom_range(0, 3) == 0 ? 32767 : $urandom_range(4000, 32767);
      rate = $urandom_range(0, 2) != 0 ? $urandom_range(0, 800) - 400 : int'($urandom);
      case ($urandom_range(0, 2))
        0:       jit = 0;
        1:       jit = 64;
        default: jit = 2048;
      endcase
      theta = $urandom;
      n = $urandom_range(40, 160);
      repeat (n) begin
        case ($urandom_range(0, 99)) inside
          [0:7]: begin
            s = 16'($urandom);
            c = 16'($urandom);
          end
          default: begin
            if ($urandom_range(0, 99) < 3) begin
              theta = $urandom;
            end
            theta = theta + rate;
            s = sat16(((sb.wave(theta[15:0]) * amp) >>> 15) +
                      int'($urandom_range(0, 2 * jit)) - jit);
            c = sat16(((sb.wave(theta[15:0] + 16'd16384) * amp) >>> 15) +
                      int'($urandom_range(0, 2 * jit)) - jit);
          end
        endcase
        send_sample(s, c);
        if ($urandom_range(0, 63) == 0) begin
          settle(0);
        end
      end
    end

    settle(SETTLE_CYCLES);
    sb.close();
    if (sb.fails == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/atp_pkg.sv
hdl/atp_sine.sv
hdl/angle_tracking_pll_top.sv
tb/tb.sv
